// ===== design/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator package
// Shared widths, request codes, status codes and controller states.
// ----------------------------------------------------------------------------
package rse_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = 8;
	localparam int CNT_W       = $clog2(DATA_W);

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SP_W-1:0]   sp_t;

	localparam logic [2:0] REQ_PUSH   = 3'd0;
	localparam logic [2:0] REQ_ADD    = 3'd1;
	localparam logic [2:0] REQ_SUB    = 3'd2;
	localparam logic [2:0] REQ_MUL    = 3'd3;
	localparam logic [2:0] REQ_DIV    = 3'd4;
	localparam logic [2:0] REQ_EQUALS = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_DIVZERO   = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_RESP
	} state_t;

endpackage

// ===== design/rse_stack_ram.sv =====
// ----------------------------------------------------------------------------
// Stack RAM
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module rse_stack_ram (
	input  logic          clk,
	input  logic          wr_en,
	input  rse_pkg::addr_t wr_addr,
	input  rse_pkg::word_t wr_data,
	input  logic          rd_en,
	input  rse_pkg::addr_t rd_addr,
	output rse_pkg::word_t rd_data
);

	rse_pkg::word_t mem [rse_pkg::STACK_DEPTH];
	rse_pkg::word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/rse_divider.sv =====
// ----------------------------------------------------------------------------
// Signed divider
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward
// zero. The divisor must be nonzero when start is raised.
// ----------------------------------------------------------------------------
module rse_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rse_pkg::word_t dividend,
	input  rse_pkg::word_t divisor,
	output logic           done,
	output rse_pkg::word_t quotient
);

	logic                         run_q;
	logic                         done_q;
	logic [rse_pkg::CNT_W-1:0]    cnt_q;
	rse_pkg::word_t               rem_q;
	rse_pkg::word_t               quo_q;
	rse_pkg::word_t               mb_q;
	logic                         neg_q;

	logic [rse_pkg::DATA_W:0]     shifted;
	logic [rse_pkg::DATA_W:0]     diff;
	rse_pkg::word_t               ma;
	rse_pkg::word_t               mb;

	always_comb begin
		ma      = dividend[rse_pkg::DATA_W-1] ? (rse_pkg::DATA_W'(0) - dividend) : dividend;
		mb      = divisor[rse_pkg::DATA_W-1] ? (rse_pkg::DATA_W'(0) - divisor) : divisor;
		shifted = {rem_q, quo_q[rse_pkg::DATA_W-1]};
		diff    = shifted - {1'b0, mb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + rse_pkg::CNT_W'(1);
				if (cnt_q == rse_pkg::CNT_W'(rse_pkg::DATA_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of quo_q from the top while quotient bits enter
	// at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= ma;
			mb_q  <= mb;
			neg_q <= dividend[rse_pkg::DATA_W-1] ^ divisor[rse_pkg::DATA_W-1];
		end else if (run_q) begin
			if (!diff[rse_pkg::DATA_W]) begin
				rem_q <= diff[rse_pkg::DATA_W-1:0];
				quo_q <= {quo_q[rse_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[rse_pkg::DATA_W-1:0];
				quo_q <= {quo_q[rse_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (rse_pkg::DATA_W'(0) - quo_q) : quo_q;

endmodule

// ===== design/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator
// 32-bit integer stack machine for reverse Polish expressions.
// ----------------------------------------------------------------------------
// One input transaction is one token and gives exactly one result transaction.
// Tokens are handled one at a time: push, add, subtract, multiply, equals,
// divide by zero and unused codes go through accept and read the second
// entry, compute and commit before the next acceptance. Divide with a
// nonzero divisor also waits for the radix-2 divider, which produces one
// quotient bit per cycle. The top entry is held in a register and the rest
// of the stack lives in a 128-word RAM with a registered read. A finished
// result waits in the output register while the next token is accepted;
// the commit of that next token waits until the output register is free.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] operand_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] top_value,
	output logic [7:0]         stack_depth,
	output logic [1:0]         status,
	output logic               is_final
);

	rse_pkg::state_t state_q, state_d;

	rse_pkg::sp_t    sp_q;
	rse_pkg::word_t  top_q;
	logic [2:0]      req_q;
	rse_pkg::word_t  val_q;

	rse_pkg::word_t  res_top_q;
	rse_pkg::word_t  res_newtop_q;
	rse_pkg::sp_t    res_sp_q;
	logic [1:0]      res_status_q;
	logic            res_final_q;
	logic            res_wr_q;
	rse_pkg::addr_t  res_addr_q;

	logic            out_valid_q;
	rse_pkg::word_t  out_top_q;
	rse_pkg::sp_t    out_sp_q;
	logic [1:0]      out_status_q;
	logic            out_final_q;

	logic            accept;
	logic            commit;
	logic            div_start;
	logic            div_done;
	rse_pkg::word_t  div_quot;
	rse_pkg::word_t  rd_data;
	rse_pkg::addr_t  rd_addr;

	logic            has_a;
	logic            has_b;
	rse_pkg::word_t  op_a;
	rse_pkg::word_t  op_b;
	rse_pkg::sp_t    base_sp;

	rse_pkg::word_t  x_top;
	rse_pkg::word_t  x_newtop;
	rse_pkg::sp_t    x_sp;
	logic [1:0]      x_status;
	logic            x_final;
	logic            x_wr;
	rse_pkg::addr_t  x_addr;

	assign accept  = in_valid && in_ready;
	assign rd_addr = rse_pkg::ADDR_W'(sp_q - rse_pkg::SP_W'(2));

	rse_stack_ram u_ram (
		.clk     (clk),
		.wr_en   (commit && res_wr_q),
		.wr_addr (res_addr_q),
		.wr_data (res_top_q),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rse_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (op_a),
		.divisor  (op_b),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Operands and the result of the token in the execute cycle.
	always_comb begin
		has_b   = (sp_q != '0);
		has_a   = (sp_q >= rse_pkg::SP_W'(2));
		op_b    = has_b ? top_q : '0;
		op_a    = has_a ? rd_data : '0;
		base_sp = has_a ? (sp_q - rse_pkg::SP_W'(2)) : '0;

		x_top    = op_b;
		x_newtop = top_q;
		x_sp     = sp_q;
		x_status = rse_pkg::ST_OK;
		x_final  = 1'b0;
		x_wr     = 1'b0;
		x_addr   = base_sp[rse_pkg::ADDR_W-1:0];

		case (req_q)
			rse_pkg::REQ_PUSH: begin
				if (sp_q < rse_pkg::SP_W'(rse_pkg::STACK_DEPTH)) begin
					x_top    = val_q;
					x_newtop = val_q;
					x_sp     = sp_q + rse_pkg::SP_W'(1);
					x_wr     = 1'b1;
					x_addr   = sp_q[rse_pkg::ADDR_W-1:0];
				end else begin
					x_top    = top_q;
					x_status = rse_pkg::ST_OVERFLOW;
				end
			end
			rse_pkg::REQ_ADD, rse_pkg::REQ_SUB, rse_pkg::REQ_MUL, rse_pkg::REQ_DIV: begin
				case (req_q)
					rse_pkg::REQ_ADD: x_top = op_a + op_b;
					rse_pkg::REQ_SUB: x_top = op_a - op_b;
					rse_pkg::REQ_MUL: x_top = op_a * op_b;
					default:          x_top = '0;
				endcase
				x_newtop = x_top;
				x_sp     = base_sp + rse_pkg::SP_W'(1);
				x_wr     = 1'b1;
				if (req_q == rse_pkg::REQ_DIV && op_b == '0) begin
					x_status = rse_pkg::ST_DIVZERO;
				end
				// A missing operand outranks divide by zero.
				if (!has_a) begin
					x_status = rse_pkg::ST_UNDERFLOW;
				end
			end
			rse_pkg::REQ_EQUALS: begin
				x_final  = 1'b1;
				x_newtop = rd_data;
				if (has_b) begin
					x_sp = sp_q - rse_pkg::SP_W'(1);
				end else begin
					x_status = rse_pkg::ST_UNDERFLOW;
				end
			end
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == rse_pkg::S_EXEC) && (req_q == rse_pkg::REQ_DIV)
		&& (op_b != '0);
	assign commit    = (state_q == rse_pkg::S_RESP) && (!out_valid_q || out_ready);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			rse_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = rse_pkg::S_EXEC;
				end
			end
			rse_pkg::S_EXEC: begin
				state_d = div_start ? rse_pkg::S_DIV : rse_pkg::S_RESP;
			end
			rse_pkg::S_DIV: begin
				if (div_done) begin
					state_d = rse_pkg::S_RESP;
				end
			end
			rse_pkg::S_RESP: begin
				if (commit) begin
					state_d = rse_pkg::S_IDLE;
				end
			end
			default: state_d = rse_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rse_pkg::S_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				sp_q        <= res_sp_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			val_q <= $unsigned(operand_value);
		end
		if (state_q == rse_pkg::S_EXEC) begin
			res_top_q    <= x_top;
			res_newtop_q <= x_newtop;
			res_sp_q     <= x_sp;
			res_status_q <= x_status;
			res_final_q  <= x_final;
			res_wr_q     <= x_wr;
			res_addr_q   <= x_addr;
		end else if (state_q == rse_pkg::S_DIV && div_done) begin
			res_top_q    <= div_quot;
			res_newtop_q <= div_quot;
		end
		if (commit) begin
			top_q        <= res_newtop_q;
			out_top_q    <= res_top_q;
			out_sp_q     <= res_sp_q;
			out_status_q <= res_status_q;
			out_final_q  <= res_final_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign top_value   = $signed(out_top_q);
	assign stack_depth = out_sp_q;
	assign status      = out_status_q;
	assign is_final    = out_final_q;

endmodule
